FILE: sv/mcm_pkg.sv
// Shared types, sizes and state encodings for the matrix chain cost block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mcm_pkg;

    // Largest chain the block stores; the index and count widths below are sized from it.
    localparam int MAX_MATRICES = 16;

    localparam int DIM_W   = 12;
    localparam int COST_W  = 40;
    localparam int IDX_W   = $clog2(MAX_MATRICES);
    localparam int CNT_W   = $clog2(MAX_MATRICES + 1);
    localparam int COST_AW = 2 * IDX_W;
    localparam int PAIR_W  = 2 * DIM_W;
    localparam int PROD_W  = 3 * DIM_W;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic             last_matrix;
    } mcm_in_t;

    typedef struct packed {
        logic [COST_W-1:0] min_cost;
        logic              chain_error;
    } mcm_out_t;

    // Control from the sequencer to the shared cost unit.
    typedef struct packed {
        logic load_pi;
        logic load_pij;
        logic issue;
        logic zero_a;
        logic zero_b;
    } mcm_ctrl_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_PI,
        SEQ_PJ,
        SEQ_MUL,
        SEQ_RUN,
        SEQ_DRAIN
    } seq_state_t;

    typedef enum logic {
        TOP_LOAD,
        TOP_SEARCH
    } top_state_t;

endpackage : mcm_pkg

`default_nettype wire

FILE: sv/mcm_dim_store.sv
// Dimension list store: p[0] in a register, p[1..N] in a small memory.
// Two registered read ports for the sequencer. Depends on mcm_pkg.
`default_nettype none

module mcm_dim_store (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic                      wr_first,
    input  wire logic [mcm_pkg::CNT_W-1:0] wr_addr,
    input  wire logic [mcm_pkg::DIM_W-1:0] first_data,
    input  wire logic [mcm_pkg::DIM_W-1:0] wr_data,
    input  wire logic [mcm_pkg::CNT_W-1:0] rd_addr_a,
    input  wire logic [mcm_pkg::CNT_W-1:0] rd_addr_b,
    output logic      [mcm_pkg::DIM_W-1:0] rd_data_a,
    output logic      [mcm_pkg::DIM_W-1:0] rd_data_b
);
    import mcm_pkg::*;

    logic [DIM_W-1:0] mem [MAX_MATRICES+1];
    logic [DIM_W-1:0] p0_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
            if (wr_first)
            begin
                p0_reg <= first_data;
            end
        end
    end

    // Entry zero lives in its own register so the first item can write two entries.
    always_ff @(posedge clk)
    begin
        rd_data_a <= (rd_addr_a == '0) ? p0_reg : mem[rd_addr_a];
        rd_data_b <= (rd_addr_b == '0) ? p0_reg : mem[rd_addr_b];
    end

endmodule : mcm_dim_store

`default_nettype wire

FILE: sv/mcm_cost_store.sv
// Cost table memory indexed by {i, j}: one write port, two registered reads.
// Depends on mcm_pkg.
`default_nettype none

module mcm_cost_store (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [mcm_pkg::COST_AW-1:0] wr_addr,
    input  wire logic [mcm_pkg::COST_W-1:0]  wr_data,
    input  wire logic [mcm_pkg::COST_AW-1:0] rd_addr_a,
    input  wire logic [mcm_pkg::COST_AW-1:0] rd_addr_b,
    output logic      [mcm_pkg::COST_W-1:0]  rd_data_a,
    output logic      [mcm_pkg::COST_W-1:0]  rd_data_b
);
    import mcm_pkg::*;

    logic [COST_W-1:0] mem [2**COST_AW];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule : mcm_cost_store

`default_nettype wire

FILE: sv/mcm_cost_unit.sv
// Shared cost unit: one multiplier, two saturating adders and the running
// minimum, pipelined so one split can enter per cycle. Depends on mcm_pkg.
`default_nettype none

module mcm_cost_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mcm_pkg::mcm_ctrl_t         ctrl,
    input  wire logic [mcm_pkg::DIM_W-1:0]  dim_a,
    input  wire logic [mcm_pkg::DIM_W-1:0]  dim_b,
    input  wire logic [mcm_pkg::COST_W-1:0] cost_a,
    input  wire logic [mcm_pkg::COST_W-1:0] cost_b,
    output logic                            busy,
    output logic      [mcm_pkg::COST_W-1:0] best
);
    import mcm_pkg::*;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

    logic [DIM_W-1:0]  pi_reg;
    logic [PAIR_W-1:0] pij_reg;
    logic              v1_reg;
    logic              za1_reg;
    logic              zb1_reg;
    logic              v2_reg;
    logic [COST_W-1:0] sum2_reg;
    logic [PROD_W-1:0] prod2_reg;
    logic [COST_W-1:0] best_reg;

    logic [PAIR_W-1:0] mul_a;
    logic [DIM_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [COST_W-1:0] term_a;
    logic [COST_W-1:0] term_b;
    logic [COST_W-1:0] q;

    // The one multiplier forms p[i]*p[j+1] once per interval, then that pair
    // times p[k+1] for every split.
    always_comb
    begin
        mul_a  = ctrl.load_pij ? PAIR_W'(pi_reg) : pij_reg;
        mul_b  = ctrl.load_pij ? dim_b : dim_a;
        mul_p  = mul_a * mul_b;
        term_a = za1_reg ? '0 : cost_a;
        term_b = zb1_reg ? '0 : cost_b;
        q      = sat_add(sum2_reg, COST_W'(prod2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_pi)
        begin
            pi_reg <= dim_b;
        end
        if (ctrl.load_pij)
        begin
            pij_reg <= mul_p[PAIR_W-1:0];
        end
        za1_reg   <= ctrl.zero_a;
        zb1_reg   <= ctrl.zero_b;
        sum2_reg  <= sat_add(term_a, term_b);
        prod2_reg <= mul_p;
        if (ctrl.load_pij)
        begin
            best_reg <= COST_MAX;
        end
        else if (v2_reg && (q < best_reg))
        begin
            best_reg <= q;
        end
    end

    assign busy = v1_reg | v2_reg;
    assign best = best_reg;

    // A new interval must never start while splits of the previous one remain.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_pij |-> !busy)
        else $error("interval started with splits still in the pipeline");

endmodule : mcm_cost_unit

`default_nettype wire

FILE: sv/mcm_seq.sv
// Sequencer of the interval search: walks length, start and split, drives
// the store addresses and the cost unit. Depends on mcm_pkg.
`default_nettype none

module mcm_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [mcm_pkg::CNT_W-1:0]   n,
    input  wire logic                        unit_busy,
    output mcm_pkg::mcm_ctrl_t               ctrl,
    output logic      [mcm_pkg::CNT_W-1:0]   dim_addr_a,
    output logic      [mcm_pkg::CNT_W-1:0]   dim_addr_b,
    output logic      [mcm_pkg::COST_AW-1:0] cost_raddr_a,
    output logic      [mcm_pkg::COST_AW-1:0] cost_raddr_b,
    output logic                             cost_we,
    output logic      [mcm_pkg::COST_AW-1:0] cost_waddr,
    output logic                             done
);
    import mcm_pkg::*;

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic [CNT_W-1:0] j_plus;
    logic [IDX_W-1:0] j_idx;
    logic [IDX_W-1:0] k1_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            n_reg     <= '0;
            len_reg   <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            len_reg   <= len_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        j_plus = CNT_W'(i_reg) + len_reg;
        j_idx  = IDX_W'(j_plus - CNT_W'(1));
        k1_idx = IDX_W'(CNT_W'(k_reg) + CNT_W'(1));

        state_next   = state_reg;
        n_next       = n_reg;
        len_next     = len_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        ctrl         = '0;
        dim_addr_a   = CNT_W'(k1_idx);
        dim_addr_b   = '0;
        cost_raddr_a = {i_reg, k_reg};
        cost_raddr_b = {k1_idx, j_idx};
        cost_we      = 1'b0;
        cost_waddr   = {i_reg, j_idx};
        done         = 1'b0;

        case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    n_next     = n;
                    len_next   = CNT_W'(2);
                    i_next     = '0;
                    state_next = SEQ_PI;
                end
            end
            SEQ_PI:
            begin
                dim_addr_b = CNT_W'(i_reg);
                state_next = SEQ_PJ;
            end
            SEQ_PJ:
            begin
                ctrl.load_pi = 1'b1;
                dim_addr_b   = j_plus;
                state_next   = SEQ_MUL;
            end
            SEQ_MUL:
            begin
                ctrl.load_pij = 1'b1;
                k_next        = i_reg;
                state_next    = SEQ_RUN;
            end
            SEQ_RUN:
            begin
                // Diagonal entries are zero and never stored, so flag them.
                ctrl.issue  = 1'b1;
                ctrl.zero_a = (k_reg == i_reg);
                ctrl.zero_b = (k1_idx == j_idx);
                k_next      = k1_idx;
                if (k1_idx == j_idx)
                begin
                    state_next = SEQ_DRAIN;
                end
            end
            SEQ_DRAIN:
            begin
                if (!unit_busy)
                begin
                    cost_we = 1'b1;
                    if (j_plus == n_reg)
                    begin
                        if (len_reg == n_reg)
                        begin
                            done       = 1'b1;
                            state_next = SEQ_IDLE;
                        end
                        else
                        begin
                            len_next   = len_reg + CNT_W'(1);
                            i_next     = '0;
                            state_next = SEQ_PI;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = SEQ_PI;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule : mcm_seq

`default_nettype wire

FILE: sv/matrix_chain_min_cost.sv
// Top level of the matrix chain cost block: input handshake, chain loading,
// error tracking and result register. Depends on mcm_pkg, mcm_dim_store,
// mcm_cost_store, mcm_cost_unit and mcm_seq.
//
// Use: one item per matrix arrives on the item channel (rows, cols and a
// last_matrix flag). Each item is accepted and, unless the chain is full, stored; items
// that are not flagged last give no result. When the last matrix arrives the
// block gives one item on the result channel: the minimum number of scalar
// multiplications for the chain, or chain_error with a zero cost when a
// matrix's rows did not match the previous matrix's cols or more than
// MAX_MATRICES matrices were sent.
//
// Timing: an erroneous chain or a single matrix gives its result in the
// cycle after the last item. Otherwise the interval search runs on one
// shared multiply/add/compare pipeline taking one split per cycle; each
// interval loads p[i] and p[j+1], forms their product, issues its splits
// and drains the pipeline before its cost is written to the cost store.
// item_ready is low during the search.
//
// Stalls: the result sits in an output register until taken, and item_ready
// stays low while it waits, so the next chain is held off until then. Reset
// empties the chain and drops any waiting result; the stores need no clearing.
`default_nettype none

module matrix_chain_min_cost (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire mcm_pkg::mcm_in_t item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output mcm_pkg::mcm_out_t     result
);
    import mcm_pkg::*;

    top_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             err_reg, err_next;
    logic [DIM_W-1:0] prev_cols_reg, prev_cols_next;
    mcm_out_t         result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic             accept;
    logic             full;
    logic             mismatch;
    logic             store;
    logic             err_now;
    logic [CNT_W-1:0] count_inc;
    logic             search_start;

    mcm_ctrl_t          ctrl;
    logic [CNT_W-1:0]   dim_addr_a;
    logic [CNT_W-1:0]   dim_addr_b;
    logic [DIM_W-1:0]   dim_data_a;
    logic [DIM_W-1:0]   dim_data_b;
    logic [COST_AW-1:0] cost_raddr_a;
    logic [COST_AW-1:0] cost_raddr_b;
    logic [COST_W-1:0]  cost_data_a;
    logic [COST_W-1:0]  cost_data_b;
    logic               cost_we;
    logic [COST_AW-1:0] cost_waddr;
    logic               unit_busy;
    logic [COST_W-1:0]  best;
    logic               search_done;

    // Loading only, and only while the output register is free or freeing.
    assign item_ready = (state_reg == TOP_LOAD) && (!result_valid_reg || result_ready);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        full      = (count_reg == CNT_W'(MAX_MATRICES));
        mismatch  = (count_reg != '0) && (item.rows != prev_cols_reg);
        store     = accept && !full;
        err_now   = err_reg || full || mismatch;
        count_inc = full ? count_reg : count_reg + CNT_W'(1);

        state_next        = state_reg;
        count_next        = count_reg;
        err_next          = err_reg;
        prev_cols_next    = prev_cols_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        search_start      = 1'b0;

        if (accept)
        begin
            if (store)
            begin
                prev_cols_next = item.cols;
            end
            count_next = count_inc;
            err_next   = err_now;
            if (item.last_matrix)
            begin
                count_next = '0;
                err_next   = 1'b0;
                if (err_now)
                begin
                    result_next.min_cost    = '0;
                    result_next.chain_error = 1'b1;
                    result_valid_next       = 1'b1;
                end
                else if (count_inc == CNT_W'(1))
                begin
                    result_next.min_cost    = '0;
                    result_next.chain_error = 1'b0;
                    result_valid_next       = 1'b1;
                end
                else
                begin
                    search_start = 1'b1;
                    state_next   = TOP_SEARCH;
                end
            end
        end

        if ((state_reg == TOP_SEARCH) && search_done)
        begin
            result_next.min_cost    = best;
            result_next.chain_error = 1'b0;
            result_valid_next       = 1'b1;
            state_next              = TOP_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= TOP_LOAD;
            count_reg        <= '0;
            err_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            err_reg          <= err_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_cols_reg <= prev_cols_next;
        result_reg    <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The first matrix also supplies p[0]; the cols go to entry count+1.
    mcm_dim_store u_dim_store (
        .clk        (clk),
        .wr_en      (store),
        .wr_first   (count_reg == '0),
        .wr_addr    (count_reg + CNT_W'(1)),
        .first_data (item.rows),
        .wr_data    (item.cols),
        .rd_addr_a  (dim_addr_a),
        .rd_addr_b  (dim_addr_b),
        .rd_data_a  (dim_data_a),
        .rd_data_b  (dim_data_b)
    );

    mcm_cost_store u_cost_store (
        .clk       (clk),
        .wr_en     (cost_we),
        .wr_addr   (cost_waddr),
        .wr_data   (best),
        .rd_addr_a (cost_raddr_a),
        .rd_addr_b (cost_raddr_b),
        .rd_data_a (cost_data_a),
        .rd_data_b (cost_data_b)
    );

    mcm_cost_unit u_cost_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .dim_a  (dim_data_a),
        .dim_b  (dim_data_b),
        .cost_a (cost_data_a),
        .cost_b (cost_data_b),
        .busy   (unit_busy),
        .best   (best)
    );

    mcm_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (search_start),
        .n            (count_inc),
        .unit_busy    (unit_busy),
        .ctrl         (ctrl),
        .dim_addr_a   (dim_addr_a),
        .dim_addr_b   (dim_addr_b),
        .cost_raddr_a (cost_raddr_a),
        .cost_raddr_b (cost_raddr_b),
        .cost_we      (cost_we),
        .cost_waddr   (cost_waddr),
        .done         (search_done)
    );

    // The output register is always empty by the time a search finishes.
    a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        search_done |-> !result_valid_reg)
        else $error("search result would overwrite a waiting result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_MATRICES))
        else $error("matrix count beyond capacity");

    a_error_zero_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.chain_error) |-> (result_reg.min_cost == '0))
        else $error("error result carries a non-zero cost");

endmodule : matrix_chain_min_cost

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the matrix chain cost block (matrix_chain_min_cost).
// Depends on mcm_pkg for the item and result types and the chain capacity.
`timescale 1ns / 1ps

module testbench;

    import mcm_pkg::*;

    // Roughly how many matrices the stimulus holds in total.
    localparam int STIMULUS_ITEMS = 550;
    // Longer than a sixteen-matrix search, the longest there is, so this covers any search
    // still running once the last expected result has been taken.
    localparam int DRAIN_CYCLES   = 1500;
    // Far beyond the slowest correct run, even with every chain at full
    // length and every stall taken.
    localparam int CYCLE_LIMIT    = 600000;
    // The long receiver hold-off starts once this many matrices are in.
    localparam int HOLD_TRIGGER   = 300;
    localparam int HOLD_CYCLES    = 3000;

    typedef enum int {
        CH_CLEAN,
        CH_MISMATCH,
        CH_OVERLONG
    } chain_kind_t;

    logic     clk;
    logic     rst_n;
    logic     item_valid = 1'b0;
    logic     item_ready;
    mcm_in_t  item = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    mcm_out_t result;

    matrix_chain_min_cost i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Matrices waiting to be offered, and the results owed by the block
    // for chains that have been closed by a last item.
    mcm_in_t  matrix_q[$];
    mcm_out_t cost_q[$];

    // Our own view of the chain being loaded: the dimension list, how many
    // matrices it holds and whether anything has gone wrong with it.
    logic [DIM_W-1:0] chain_dims [0:MAX_MATRICES];
    int               chain_len    = 0;
    bit               chain_broken = 1'b0;

    int matrices_taken    = 0;
    int chains_checked    = 0;
    int chain_errors_seen = 0;
    int fail_count        = 0;
    int cycle_count       = 0;
    int hold_left         = 0;
    bit hold_done         = 1'b0;
    mcm_out_t awaited;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Every partial cost saturates at the all-ones value of the cost field.
    function automatic logic [63:0] capped(input logic [63:0] v);
        return (v > 64'(COST_MAX)) ? 64'(COST_MAX) : v;
    endfunction

    // Classic interval search over the stored dimension list. Each interval
    // starts from the saturated value and only a strictly cheaper split
    // replaces the current best, so the lowest split point wins a tie.
    function automatic logic [COST_W-1:0] cheapest_order(input int n);
        logic [63:0] best [MAX_MATRICES][MAX_MATRICES];
        logic [63:0] trial;
        logic [63:0] prod;
        int          j;
        for (int i = 0; i < n; i++)
            best[i][i] = '0;
        for (int span = 2; span <= n; span++)
        begin
            for (int i = 0; i + span <= n; i++)
            begin
                j = i + span - 1;
                best[i][j] = 64'(COST_MAX);
                for (int k = i; k < j; k++)
                begin
                    prod  = 64'(chain_dims[i]) * 64'(chain_dims[k + 1])
                          * 64'(chain_dims[j + 1]);
                    trial = capped(capped(best[i][k] + best[k + 1][j]) + capped(prod));
                    if (trial < best[i][j])
                        best[i][j] = trial;
                end
            end
        end
        return best[0][n - 1][COST_W-1:0];
    endfunction

    // Folds one accepted matrix into the chain. A matrix that arrives once
    // the chain is full is dropped and spoils the chain; a matrix whose rows
    // differ from the previous columns also spoils it, but its columns are
    // still kept. The last matrix closes the chain and owes one result.
    task automatic absorb_matrix(input mcm_in_t m);
        mcm_out_t outcome;
        if (chain_len >= MAX_MATRICES)
            chain_broken = 1'b1;
        else
        begin
            if (chain_len == 0)
                chain_dims[0] = m.rows;
            else if (chain_dims[chain_len] != m.rows)
                chain_broken = 1'b1;
            chain_dims[chain_len + 1] = m.cols;
            chain_len++;
        end
        if (m.last_matrix)
        begin
            outcome.chain_error = chain_broken;
            outcome.min_cost    = chain_broken ? '0 : cheapest_order(chain_len);
            cost_q.push_back(outcome);
            chain_len    = 0;
            chain_broken = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic push_matrix(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c,
                               input bit last);
        mcm_in_t m;
        m.rows        = r;
        m.cols        = c;
        m.last_matrix = last;
        matrix_q.push_back(m);
    endtask

    // Dimensions lean towards small values so that costs stay readable, but
    // the extremes and the full range turn up often enough to toggle every bit.
    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        if (roll < 55)
            return DIM_W'($urandom_range(1, 16));
        if (roll < 75)
            return DIM_W'($urandom_range(1, 255));
        return DIM_W'($urandom_range(0, 4095));
    endfunction

    // Builds one chain of n matrices from a random dimension list. A uniform
    // chain repeats one dimension throughout, which makes every split cost
    // the same. A mismatched chain gets one rows field corrupted somewhere
    // after the first matrix.
    task automatic add_chain(input int n, input chain_kind_t kind, input bit uniform);
        logic [DIM_W-1:0] p [0:MAX_MATRICES+4];
        logic [DIM_W-1:0] r;
        int               bad_at;
        p[0] = pick_dim();
        for (int i = 1; i <= n; i++)
            p[i] = uniform ? p[0] : pick_dim();
        bad_at = (kind == CH_MISMATCH) ? $urandom_range(1, n - 1) : -1;
        for (int i = 0; i < n; i++)
        begin
            r = p[i];
            if (i == bad_at)
                r = p[i] ^ DIM_W'($urandom_range(1, 4095));
            push_matrix(r, p[i + 1], i == n - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers matrices from the queue. The item is taken over at the
    // edge where valid and ready are both high; only then is the item replaced
    // or valid dropped, so valid and its payload never move while waiting.
    // Between the 150th and 250th matrix the driver never idles.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid     <= 1'b0;
            item           <= '0;
            matrices_taken <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                absorb_matrix(item);
                matrices_taken <= matrices_taken + 1;
            end
            if (!item_valid || item_ready)
            begin
                if (matrix_q.size() != 0 &&
                    ((matrices_taken >= 150 && matrices_taken < 250) ||
                     $urandom_range(0, 99) >= 25))
                begin
                    item       <= matrix_q.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long hold-off: once enough matrices are in, the receiver refuses
    // results for a long stretch while the driver keeps offering. The block
    // then keeps a result waiting and has to hold its input off until the
    // stretch ends.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && matrices_taken >= HOLD_TRIGGER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result taken against the oldest one owed, field
    // by field, and drives ready with random stalls. Between the 30th and
    // 55th result the receiver never stalls outside the long hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (cost_q.size() == 0)
                begin
                    report_mismatch($sformatf("result with no chain pending: cost %0d error %0b",
                                              result.min_cost, result.chain_error));
                end
                else
                begin
                    awaited = cost_q.pop_front();
                    if (result.min_cost !== awaited.min_cost)
                        report_mismatch($sformatf("chain %0d min_cost %0d, expected %0d",
                                                  chains_checked, result.min_cost,
                                                  awaited.min_cost));
                    if (result.chain_error !== awaited.chain_error)
                        report_mismatch($sformatf("chain %0d chain_error %0b, expected %0b",
                                                  chains_checked, result.chain_error,
                                                  awaited.chain_error));
                    if (awaited.chain_error)
                        chain_errors_seen++;
                    chains_checked++;
                end
            end
            result_ready <= (hold_left == 0) &&
                            ((chains_checked >= 30 && chains_checked < 55) ||
                             $urandom_range(0, 99) >= 25);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, cost_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build the stimulus, release reset, wait for every
    // result to come back, let any late search run out, then give verdict.
    // ------------------------------------------------------------------
    initial
    begin
        int          roll;
        int          len_roll;
        int          n;
        chain_kind_t kind;

        rst_n = 1'b0;

        // Directed part. A lone matrix with a zero dimension costs nothing.
        push_matrix(12'd0, 12'd4095, 1'b1);
        // Neighbouring dimensions disagree, so the chain is flagged.
        push_matrix(12'd5, 12'd7, 1'b0);
        push_matrix(12'd8, 12'd3, 1'b1);
        // Textbook chain whose best order costs 4500.
        push_matrix(12'd10, 12'd30, 1'b0);
        push_matrix(12'd30, 12'd5, 1'b0);
        push_matrix(12'd5, 12'd60, 1'b1);
        // Largest dimensions everywhere; both splits tie.
        push_matrix(12'd4095, 12'd4095, 1'b0);
        push_matrix(12'd4095, 12'd4095, 1'b0);
        push_matrix(12'd4095, 12'd4095, 1'b1);
        // One matrix more than the block can hold.
        add_chain(MAX_MATRICES + 1, CH_OVERLONG, 1'b1);

        // A full-capacity chain at the largest dimensions gives the highest
        // cost the block can reach and its longest search.
        for (int i = 0; i < MAX_MATRICES; i++)
            push_matrix('1, '1, i == MAX_MATRICES - 1);

        // Random part: mostly well-formed chains of modest length, with
        // mismatched and overlong chains mixed in.
        while (matrix_q.size() < STIMULUS_ITEMS)
        begin
            roll     = $urandom_range(0, 99);
            len_roll = $urandom_range(0, 99);
            if (roll < 82)
            begin
                kind = CH_CLEAN;
                if (len_roll < 70)
                    n = $urandom_range(1, 5);
                else if (len_roll < 95)
                    n = $urandom_range(6, 10);
                else
                    n = $urandom_range(11, MAX_MATRICES);
            end
            else if (roll < 97)
            begin
                kind = CH_MISMATCH;
                n    = $urandom_range(2, 8);
            end
            else
            begin
                kind = CH_OVERLONG;
                n    = $urandom_range(MAX_MATRICES + 1, MAX_MATRICES + 4);
            end
            add_chain(n, kind, $urandom_range(0, 9) == 0);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (matrix_q.size() != 0 || item_valid || cost_q.size() != 0);

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d matrices through the block and checked %0d chain results,",
                 matrices_taken, chains_checked);
        $display("%0d of them flagged as broken chains; %0d mismatches found.",
                 chain_errors_seen, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: matrix_chain_min_cost.f
sv/mcm_pkg.sv
sv/mcm_dim_store.sv
sv/mcm_cost_store.sv
sv/mcm_cost_unit.sv
sv/mcm_seq.sv
sv/matrix_chain_min_cost.sv
tb/testbench.sv
